// File: rtl/process_schedule_simulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the process schedule simulator
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SCHEDULE_SIMULATOR_ASSERT_SVH
`define PROCESS_SCHEDULE_SIMULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSS_ASSERT(lbl, prop, msg)
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types, constants and codes shared by the process schedule simulator.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int MAX_PROCS_DEF = 32;
	localparam int CLK_W = 19;
	localparam int SRV_W = 13;
	localparam int T_W = 18;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_PRIO = 2'd2;
	localparam logic [1:0] POL_RR   = 2'd3;

	typedef struct packed {
		logic [11:0] burst_time;
		logic [11:0] arrival_time;
		logic [7:0]  prio_value;
		logic        last_proc;
	} in_word_t;

	typedef struct packed {
		logic [4:0]     proc_index;
		logic [T_W-1:0] response_time;
		logic [T_W-1:0] completion_time;
		logic [T_W-1:0] turnaround_time;
		logic [T_W-1:0] waiting_time;
		logic           last_result;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_OUT,
		ST_OUT_END
	} state_t;

endpackage

// File: rtl/pss_scan.sv
// ----------------------------------------------------------------------------
// pss_scan
// Shared compare unit: streams through the process entries one per cycle,
// keeps the eligible entry with the smallest key and the earliest pending
// arrival.
// ----------------------------------------------------------------------------
module pss_scan #(
	parameter int AW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      ent_vld,
	input  logic [AW-1:0]             ent_idx,
	input  logic [11:0]               ent_burst,
	input  logic [11:0]               ent_arrival,
	input  logic [7:0]                ent_prio,
	input  logic [pss_pkg::SRV_W-1:0] ent_served,
	input  logic                      ent_done,
	input  logic [1:0]                policy,
	input  logic [pss_pkg::CLK_W-1:0] sim_clock,
	output logic                      found,
	output logic [AW-1:0]             best_idx,
	output logic [11:0]               best_burst,
	output logic [11:0]               best_arrival,
	output logic [pss_pkg::SRV_W-1:0] best_served,
	output logic                      any_pending,
	output logic [11:0]               min_arrival
);
	import pss_pkg::*;

	logic [SRV_W-1:0] key, best_key_q;
	logic             elig, take;

	// select the key of the policy and test the entry
	always_comb begin
		case (policy)
			POL_FCFS: key = SRV_W'(ent_arrival);
			POL_SJF:  key = SRV_W'(ent_burst);
			POL_PRIO: key = SRV_W'(ent_prio);
			default:  key = ent_served;
		endcase
		elig = ent_vld && !ent_done && (CLK_W'(ent_arrival) <= sim_clock);
		take = elig && (!found || key < best_key_q);
	end

	// hold the best entry so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found       <= 1'b0;
			any_pending <= 1'b0;
		end else if (clr) begin
			found       <= 1'b0;
			any_pending <= 1'b0;
		end else begin
			if (take) found <= 1'b1;
			if (ent_vld && !ent_done) any_pending <= 1'b1;
		end
	end

	// payload of the winner and the earliest arrival
	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q   <= key;
			best_idx     <= ent_idx;
			best_burst   <= ent_burst;
			best_arrival <= ent_arrival;
			best_served  <= ent_served;
		end
		if (ent_vld && !ent_done && !clr && (!any_pending || ent_arrival < min_arrival))
			min_arrival <= ent_arrival;
	end

endmodule

// File: rtl/process_schedule_simulator.sv
// ----------------------------------------------------------------------------
// process_schedule_simulator
// Loads process records and simulates one CPU schedule over them.
// ----------------------------------------------------------------------------
// Usage: present a record word on cmd with start high; it is taken at an edge
// where busy is low, one record per cycle. Records beyond MAX_PROCS are
// dropped. The record with last_proc set starts the run under the policy
// register (policy_we / policy_wdata, written while idle; 0 first-come,
// 1 shortest job, 2 priority, 3 round robin).
// Each scheduling decision scans the N stored records through one compare
// unit and then decides; non-preemptive runs take one decision per process
// plus one per idle gap, round robin one decision per tick.
// Results then leave one per cycle on result, flagged by result_valid for one
// cycle, in load order; the last carries last_result. The first result shows
// via the read and result registers. busy drops as the last result is shown.
// The receiver cannot stall the results. Reset clears the record count, the
// run state and the policy (first-come); stored records need no clearing.
// ----------------------------------------------------------------------------
`include "process_schedule_simulator_assert.svh"

module process_schedule_simulator #(
	parameter int MAX_PROCS = pss_pkg::MAX_PROCS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pss_pkg::in_word_t  cmd,
	input  logic               policy_we,
	input  logic [1:0]         policy_wdata,
	output logic               result_valid,
	output pss_pkg::out_word_t result
);
	import pss_pkg::*;

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);

	state_t state_q, state_d;

	logic [1:0]       policy_q;
	logic [CW-1:0]    cnt_q, fin_q;
	logic [AW-1:0]    addr_q, last_addr;
	logic [CLK_W-1:0] clk_q;
	logic [MAX_PROCS-1:0] done_q, srv_vld_q;

	// memories
	logic [31:0]      rec_mem [MAX_PROCS];
	logic [SRV_W-1:0] srv_mem [MAX_PROCS];
	logic [T_W-1:0]   resp_mem [MAX_PROCS];
	logic [CLK_W-1:0] cmp_mem [MAX_PROCS];

	logic             rd_en, rd_out;
	logic             vld_s1, out_s1;
	logic [AW-1:0]    idx_s1;
	logic [31:0]      rec_s1;
	logic [SRV_W-1:0] srv_s1;
	logic [T_W-1:0]   resp_s1;
	logic [CLK_W-1:0] cmp_s1;
	logic [SRV_W-1:0] served_s1;

	logic             load, run_go, addr_end, scan_clr;
	logic             found, any_pending;
	logic [AW-1:0]    best_idx;
	logic [11:0]      best_burst, best_arrival, min_arrival;
	logic [SRV_W-1:0] best_served, eff_burst, new_served;
	logic             rr, fin_now;
	logic [CLK_W-1:0] clk_next, cmp_val;
	logic [CLK_W-1:0] tt, wt;

	assign load      = start && !busy;
	assign run_go    = load && cmd.last_proc;
	assign last_addr = AW'(cnt_q - CW'(1));
	assign addr_end  = (addr_q == last_addr);
	assign rr        = (policy_q == POL_RR);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (run_go) state_d = ST_SCAN;
			ST_SCAN:     if (addr_end) state_d = ST_SCAN_END;
			ST_SCAN_END: state_d = ST_DECIDE;
			ST_DECIDE:   state_d = (fin_now && (fin_q + CW'(1) == cnt_q)) ? ST_OUT : ST_SCAN;
			ST_OUT:      if (addr_end) state_d = ST_OUT_END;
			ST_OUT_END:  state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy     = (state_q != ST_IDLE);
		rd_en    = (state_q == ST_SCAN) || (state_q == ST_OUT);
		rd_out   = (state_q == ST_OUT);
		scan_clr = (state_q == ST_DECIDE) || run_go;
	end

	// decision arithmetic
	always_comb begin
		eff_burst  = (best_burst == 12'd0) ? SRV_W'(1) : SRV_W'(best_burst);
		new_served = best_served + SRV_W'(1);
		if (!found) begin
			fin_now  = 1'b0;
			clk_next = (any_pending && CLK_W'(min_arrival) > clk_q) ?
				CLK_W'(min_arrival) : clk_q + CLK_W'(1);
		end else if (rr) begin
			fin_now  = (new_served == eff_burst);
			clk_next = clk_q + CLK_W'(1);
		end else begin
			fin_now  = 1'b1;
			clk_next = clk_q + CLK_W'(best_burst);
		end
		cmp_val = clk_next;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			policy_q  <= POL_FCFS;
			cnt_q     <= '0;
			fin_q     <= '0;
			addr_q    <= '0;
			clk_q     <= '0;
			done_q    <= '0;
			srv_vld_q <= '0;
			vld_s1    <= 1'b0;
			out_s1    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (policy_we) policy_q <= policy_wdata;
			if (load && cnt_q < CW'(MAX_PROCS)) cnt_q <= cnt_q + CW'(1);
			if (run_go) begin
				fin_q     <= '0;
				clk_q     <= '0;
				done_q    <= '0;
				srv_vld_q <= '0;
			end
			// advance the scan address
			if (rd_en) addr_q <= addr_end ? '0 : addr_q + AW'(1);
			// apply the decision
			if (state_q == ST_DECIDE) begin
				clk_q <= clk_next;
				if (found) srv_vld_q[best_idx] <= 1'b1;
				if (fin_now) begin
					done_q[best_idx] <= 1'b1;
					fin_q <= fin_q + CW'(1);
				end
			end
			if (state_q == ST_OUT_END) cnt_q <= '0;
			vld_s1 <= rd_en && !rd_out;
			out_s1 <= rd_out;
			result_valid <= out_s1;
		end
	end

	// record store and per-process run store
	always_ff @(posedge clk) begin
		if (load && cnt_q < CW'(MAX_PROCS))
			rec_mem[AW'(cnt_q)] <= {cmd.burst_time, cmd.arrival_time, cmd.prio_value};
		if (state_q == ST_DECIDE && found) begin
			srv_mem[best_idx] <= rr ? new_served : SRV_W'(best_burst);
			if (!rr || best_served == '0)
				resp_mem[best_idx] <= T_W'(clk_q - CLK_W'(best_arrival));
			if (fin_now) cmp_mem[best_idx] <= cmp_val;
		end
		if (rd_en) begin
			rec_s1  <= rec_mem[addr_q];
			srv_s1  <= srv_mem[addr_q];
			resp_s1 <= resp_mem[addr_q];
			cmp_s1  <= cmp_mem[addr_q];
			idx_s1  <= addr_q;
		end
	end

	assign served_s1 = srv_vld_q[idx_s1] ? srv_s1 : '0;

	pss_scan #(.AW(AW)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (scan_clr),
		.ent_vld      (vld_s1),
		.ent_idx      (idx_s1),
		.ent_burst    (rec_s1[31:20]),
		.ent_arrival  (rec_s1[19:8]),
		.ent_prio     (rec_s1[7:0]),
		.ent_served   (served_s1),
		.ent_done     (done_q[idx_s1]),
		.policy       (policy_q),
		.sim_clock    (clk_q),
		.found        (found),
		.best_idx     (best_idx),
		.best_burst   (best_burst),
		.best_arrival (best_arrival),
		.best_served  (best_served),
		.any_pending  (any_pending),
		.min_arrival  (min_arrival)
	);

	// form the result word
	assign tt = cmp_s1 - CLK_W'(rec_s1[19:8]);
	assign wt = tt - CLK_W'(served_s1);

	always_ff @(posedge clk) begin
		if (out_s1) begin
			result.proc_index      <= 5'(idx_s1);
			result.response_time   <= resp_s1;
			result.completion_time <= T_W'(cmp_s1);
			result.turnaround_time <= T_W'(tt);
			result.waiting_time    <= T_W'(wt);
			result.last_result     <= (idx_s1 == last_addr);
		end
	end

	`PSS_ASSERT(a_fin_le_cnt, busy |-> fin_q <= cnt_q, "finished count exceeds process count")
	`PSS_ASSERT(a_last_idle, (result_valid && result.last_result) |-> !busy, "busy after last result")
	`PSS_ASSERT_NEXT(a_run_busy, start && !busy && cmd.last_proc, busy, "run did not start")

endmodule
